### rtl/ymd_pkg.sv
// ymd_pkg: shared types and the CRC-16/XMODEM byte update for the YMODEM deframer.
// No dependencies; used by the controller, output buffer and top level.
package ymd_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // one result item as it leaves the block
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic [7:0]  seq_number;
    logic [10:0] frame_length;
    logic [2:0]  error_cause;
  } out_t;

  // result beat from the frame controller to the output buffer
  typedef struct packed {
    logic valid;
    out_t data;
  } res_beat_t;

  // MSB-first CRC update over one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/ymd_if.sv
// ymd_if: valid/ready channel interfaces for received bytes and deframer results.
// No dependencies.
interface ymd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timed_out;

  modport source (output valid, output rx_byte, output timed_out, input ready);
  modport sink   (input valid, input rx_byte, input timed_out, output ready);
endinterface

interface ymd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic [9:0]  payload_index;
  logic [7:0]  seq_number;
  logic [10:0] frame_length;
  logic [2:0]  error_cause;

  modport source (output valid, output kind, output payload_byte, output payload_index,
                  output seq_number, output frame_length, output error_cause, input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_index,
                  input seq_number, input frame_length, input error_cause, output ready);
endinterface

### rtl/ymd_frame_ctl.sv
// ymd_frame_ctl: frame state machine, payload counter and running CRC.
// Depends on ymd_pkg (out_t, res_beat_t, crc_byte).
module ymd_frame_ctl #(
  parameter int SHORT_PAYLOAD = 128,
  parameter int LONG_PAYLOAD  = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         rx_byte,
  input  logic               timed_out,
  output ymd_pkg::res_beat_t res
);

  localparam int CW = $clog2(LONG_PAYLOAD + 1);

  // control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_CAN = 8'h18;

  // result kinds
  localparam logic [2:0] K_PAYLOAD = 3'd0;
  localparam logic [2:0] K_GOOD    = 3'd1;
  localparam logic [2:0] K_EOT     = 3'd2;
  localparam logic [2:0] K_CANCEL  = 3'd3;
  localparam logic [2:0] K_ERROR   = 3'd4;

  // error causes
  localparam logic [2:0] E_BAD_START = 3'd1;
  localparam logic [2:0] E_TIMEOUT   = 3'd2;
  localparam logic [2:0] E_SEQ       = 3'd3;
  localparam logic [2:0] E_CRC       = 3'd4;
  localparam logic [2:0] E_CAN       = 3'd5;

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_CAN  = 7'b0000010,
    PH_SEQ  = 7'b0000100,
    PH_SEQC = 7'b0001000,
    PH_DATA = 7'b0010000,
    PH_CRCH = 7'b0100000,
    PH_CRCL = 7'b1000000
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic            long_r, long_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      seq_r, seq_nxt;
  logic            seqok_r, seqok_nxt;
  logic [7:0]      crch_r, crch_nxt;

  logic [CW-1:0]   frame_size;
  logic [CW-1:0]   cnt_inc;
  logic            in_frame;

  assign frame_size = long_r ? CW'(LONG_PAYLOAD) : CW'(SHORT_PAYLOAD);
  assign cnt_inc    = cnt_r + CW'(1);
  assign in_frame   = (phase_r != PH_IDLE) && (phase_r != PH_CAN);

  // next state and result for the byte in hand
  always_comb begin
    phase_nxt = phase_r;
    long_nxt  = long_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    seq_nxt   = seq_r;
    seqok_nxt = seqok_r;
    crch_nxt  = crch_r;
    res       = '0;
    if (fire) begin
      if (timed_out && in_frame) begin
        // timeout drops the frame
        phase_nxt              = PH_IDLE;
        res.valid              = 1'b1;
        res.data.kind          = K_ERROR;
        res.data.seq_number    = seq_r;
        res.data.error_cause   = E_TIMEOUT;
      end else begin
        case (phase_r)
          PH_IDLE: begin
            if (timed_out) begin
              res.valid            = 1'b1;
              res.data.kind        = K_ERROR;
              res.data.error_cause = E_TIMEOUT;
            end else if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
              long_nxt  = (rx_byte == CH_STX);
              cnt_nxt   = '0;
              crc_nxt   = '0;
              seq_nxt   = '0;
              seqok_nxt = 1'b0;
              crch_nxt  = '0;
              phase_nxt = PH_SEQ;
            end else if (rx_byte == CH_EOT) begin
              res.valid     = 1'b1;
              res.data.kind = K_EOT;
            end else if (rx_byte == CH_CAN) begin
              phase_nxt = PH_CAN;
            end else begin
              res.valid            = 1'b1;
              res.data.kind        = K_ERROR;
              res.data.error_cause = E_BAD_START;
            end
          end
          PH_CAN: begin
            phase_nxt = PH_IDLE;
            res.valid = 1'b1;
            if (timed_out) begin
              res.data.kind        = K_ERROR;
              res.data.error_cause = E_TIMEOUT;
            end else if (rx_byte == CH_CAN) begin
              res.data.kind = K_CANCEL;
            end else begin
              res.data.kind        = K_ERROR;
              res.data.error_cause = E_CAN;
            end
          end
          PH_SEQ: begin
            seq_nxt   = rx_byte;
            phase_nxt = PH_SEQC;
          end
          PH_SEQC: begin
            seqok_nxt = ((rx_byte ^ 8'hff) == seq_r);
            cnt_nxt   = '0;
            phase_nxt = PH_DATA;
          end
          PH_DATA: begin
            res.valid              = 1'b1;
            res.data.kind          = K_PAYLOAD;
            res.data.payload_byte  = rx_byte;
            res.data.payload_index = 10'(cnt_r);
            crc_nxt                = ymd_pkg::crc_byte(crc_r, rx_byte);
            cnt_nxt                = cnt_inc;
            if (cnt_inc >= frame_size) begin
              phase_nxt = PH_CRCH;
            end
          end
          PH_CRCH: begin
            crch_nxt  = rx_byte;
            phase_nxt = PH_CRCL;
          end
          PH_CRCL: begin
            // complement mismatch outranks CRC mismatch
            phase_nxt           = PH_IDLE;
            res.valid           = 1'b1;
            res.data.seq_number = seq_r;
            if (!seqok_r) begin
              res.data.kind        = K_ERROR;
              res.data.error_cause = E_SEQ;
            end else if ({crch_r, rx_byte} != crc_r) begin
              res.data.kind        = K_ERROR;
              res.data.error_cause = E_CRC;
            end else begin
              res.data.kind         = K_GOOD;
              res.data.frame_length = long_r ? 11'(LONG_PAYLOAD) : 11'(SHORT_PAYLOAD);
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      long_r  <= 1'b0;
      cnt_r   <= '0;
      crc_r   <= '0;
      seq_r   <= '0;
      seqok_r <= 1'b0;
      crch_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      long_r  <= long_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      seq_r   <= seq_nxt;
      seqok_r <= seqok_nxt;
      crch_r  <= crch_nxt;
    end
  end

  // payload beats only come out of the data phase
  a_payload_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.data.kind == K_PAYLOAD) |-> (phase_r == PH_DATA))
    else $error("payload beat outside data phase");

  // counter never runs past the frame size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (cnt_r < frame_size))
    else $error("payload counter overran frame");

  // last CRC byte always closes the frame with a verdict
  a_crcl_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && phase_r == PH_CRCL) |-> (res.valid && res.data.kind != K_PAYLOAD))
    else $error("no verdict at end of frame");

endmodule

### rtl/ymd_out_buf.sv
// ymd_out_buf: result register plus skid register on the output channel.
// Depends on ymd_pkg (out_t, res_beat_t) and ymd_out_if.
module ymd_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  ymd_pkg::res_beat_t res,
  output logic               room,
  ymd_out_if.source          out_if
);

  logic          out_valid_r, out_valid_nxt;
  ymd_pkg::out_t out_data_r, out_data_nxt;
  logic          skd_valid_r, skd_valid_nxt;
  ymd_pkg::out_t skd_data_r, skd_data_nxt;
  logic          stall;

  // upstream may push while the skid slot is free
  assign room  = !skd_valid_r;
  assign stall = out_valid_r && !out_if.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    skd_valid_nxt = skd_valid_r;
    skd_data_nxt  = skd_data_r;
    if (stall) begin
      if (res.valid) begin
        skd_valid_nxt = 1'b1;
        skd_data_nxt  = res.data;
      end
    end else if (skd_valid_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = skd_data_r;
      skd_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = res.valid;
      out_data_nxt  = res.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skd_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skd_valid_r <= skd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skd_data_r <= skd_data_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.kind          = out_data_r.kind;
  assign out_if.payload_byte  = out_data_r.payload_byte;
  assign out_if.payload_index = out_data_r.payload_index;
  assign out_if.seq_number    = out_data_r.seq_number;
  assign out_if.frame_length  = out_data_r.frame_length;
  assign out_if.error_cause   = out_data_r.error_cause;

  // skid only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skd_valid_r |-> out_valid_r)
    else $error("skid holds data with empty output register");

  // no push into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !skd_valid_r)
    else $error("result pushed into full buffer");

  // a drained output refills from the skid next cycle
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_if.ready && skd_valid_r) |=> (out_valid_r && !skd_valid_r))
    else $error("skid did not move to output");

endmodule

### rtl/ymodem_packet_deframer.sv
// ymodem_packet_deframer: top level of the YMODEM frame receiver (CRC-16/XMODEM).
// Depends on ymd_pkg, ymd_if, ymd_frame_ctl and ymd_out_buf.
//
//  channel  dir  handshake            beat contents
//  in_if    in   valid/ready          rx_byte, timed_out
//  out_if   out  valid/ready          kind, payload_byte, payload_index,
//                                     seq_number, frame_length, error_cause
//
// One byte is accepted every cycle while the skid register is free; the CRC update for a
// byte is done in the same cycle it is accepted, and its result is registered before out_if.
// Reset (rst_n low, synchronous) returns the receiver to idle, awaiting a start byte.
// A stalled output holds one result in its register and one more in a skid
// register; in_if.ready drops only while the skid register is occupied.
module ymodem_packet_deframer #(
  parameter int SHORT_PAYLOAD = 128,
  parameter int LONG_PAYLOAD  = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  ymd_in_if.sink     in_if,
  ymd_out_if.source  out_if
);

  ymd_pkg::res_beat_t res;
  logic               room;
  logic               fire;

  assign in_if.ready = room;
  assign fire        = in_if.valid && room;

  ymd_frame_ctl #(
    .SHORT_PAYLOAD (SHORT_PAYLOAD),
    .LONG_PAYLOAD  (LONG_PAYLOAD)
  ) u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rx_byte   (in_if.rx_byte),
    .timed_out (in_if.timed_out),
    .res       (res)
  );

  ymd_out_buf u_obuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .room   (room),
    .out_if (out_if)
  );

endmodule

### tb/ymd_deframe_checker.sv
// ymd_deframe_checker: protocol codes shared by the testbench, plus a passive checker that
// predicts the deframer's result beats from the accepted input beats and compares them.
// Depends on ymd_pkg (out_t) and ymd_if (ymd_in_if, ymd_out_if).
package ymd_tb_codes_pkg;

  // control bytes that open or end a transfer
  typedef enum logic [7:0] {
    CH_SOH = 8'h01,
    CH_STX = 8'h02,
    CH_EOT = 8'h04,
    CH_CAN = 8'h18
  } ctrl_byte_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_EOT     = 3'd2,
    KIND_CANCEL  = 3'd3,
    KIND_ERROR   = 3'd4
  } result_kind_e;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_BAD_START = 3'd1,
    CAUSE_TIMEOUT   = 3'd2,
    CAUSE_SEQ_COMPL = 3'd3,
    CAUSE_CRC       = 3'd4,
    CAUSE_LONE_CAN  = 3'd5
  } error_cause_e;

  localparam logic [15:0] CRC16_POLY = 16'h1021;

endpackage

module ymd_deframe_checker #(
  parameter int SHORT_LEN = 128,
  parameter int LONG_LEN  = 1024
) (
  input  logic clk,
  input  logic rst_n,
  ymd_in_if    in_mon,
  ymd_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   good_frames,
  output int   error_verdicts
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 40;

  typedef enum {
    PH_IDLE,
    PH_AFTER_CAN,
    PH_SEQ,
    PH_SEQ_COMPL,
    PH_PAYLOAD,
    PH_CRC_HI,
    PH_CRC_LO
  } rx_phase_e;

  // predicted receiver state
  rx_phase_e   rx_phase;
  bit          long_frame;
  int          payload_count;
  logic [15:0] crc_acc;
  logic [7:0]  seq_byte;
  bit          seq_ok;
  logic [7:0]  crc_hi;

  ymd_pkg::out_t expected_results[$];

  // bit-serial CRC-16/XMODEM: feed the byte MSB first
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ ymd_tb_codes_pkg::CRC16_POLY;
      end
    end
    return c;
  endfunction

  // advance the predicted state by one accepted beat, queue any result it causes
  task automatic deframe_step(input logic [7:0] b, input logic tmo);
    ymd_pkg::out_t res;
    bit            has_res;
    int            frame_len;
    res = '0;
    has_res = 1'b1;
    frame_len = long_frame ? LONG_LEN : SHORT_LEN;
    case (rx_phase)
      PH_IDLE: begin
        if (tmo) begin
          res.kind = ymd_tb_codes_pkg::KIND_ERROR;
          res.error_cause = ymd_tb_codes_pkg::CAUSE_TIMEOUT;
        end else if (b == ymd_tb_codes_pkg::CH_SOH || b == ymd_tb_codes_pkg::CH_STX) begin
          long_frame = (b == ymd_tb_codes_pkg::CH_STX);
          payload_count = 0;
          crc_acc = '0;
          seq_byte = '0;
          seq_ok = 1'b0;
          crc_hi = '0;
          rx_phase = PH_SEQ;
          has_res = 1'b0;
        end else if (b == ymd_tb_codes_pkg::CH_EOT) begin
          res.kind = ymd_tb_codes_pkg::KIND_EOT;
        end else if (b == ymd_tb_codes_pkg::CH_CAN) begin
          rx_phase = PH_AFTER_CAN;
          has_res = 1'b0;
        end else begin
          res.kind = ymd_tb_codes_pkg::KIND_ERROR;
          res.error_cause = ymd_tb_codes_pkg::CAUSE_BAD_START;
        end
      end
      PH_AFTER_CAN: begin
        rx_phase = PH_IDLE;
        if (tmo) begin
          res.kind = ymd_tb_codes_pkg::KIND_ERROR;
          res.error_cause = ymd_tb_codes_pkg::CAUSE_TIMEOUT;
        end else if (b == ymd_tb_codes_pkg::CH_CAN) begin
          res.kind = ymd_tb_codes_pkg::KIND_CANCEL;
        end else begin
          res.kind = ymd_tb_codes_pkg::KIND_ERROR;
          res.error_cause = ymd_tb_codes_pkg::CAUSE_LONE_CAN;
        end
      end
      default: begin
        // inside a frame: a timeout drops it whatever the position
        if (tmo) begin
          rx_phase = PH_IDLE;
          res.kind = ymd_tb_codes_pkg::KIND_ERROR;
          res.seq_number = seq_byte;
          res.error_cause = ymd_tb_codes_pkg::CAUSE_TIMEOUT;
        end else begin
          case (rx_phase)
            PH_SEQ: begin
              seq_byte = b;
              rx_phase = PH_SEQ_COMPL;
              has_res = 1'b0;
            end
            PH_SEQ_COMPL: begin
              seq_ok = (~b == seq_byte);
              payload_count = 0;
              rx_phase = PH_PAYLOAD;
              has_res = 1'b0;
            end
            PH_PAYLOAD: begin
              res.kind = ymd_tb_codes_pkg::KIND_PAYLOAD;
              res.payload_byte = b;
              res.payload_index = payload_count[9:0];
              crc_acc = crc16_next(crc_acc, b);
              payload_count++;
              if (payload_count >= frame_len) begin
                rx_phase = PH_CRC_HI;
              end
            end
            PH_CRC_HI: begin
              crc_hi = b;
              rx_phase = PH_CRC_LO;
              has_res = 1'b0;
            end
            default: begin
              // last CRC byte: complement check outranks the CRC check
              rx_phase = PH_IDLE;
              res.seq_number = seq_byte;
              if (!seq_ok) begin
                res.kind = ymd_tb_codes_pkg::KIND_ERROR;
                res.error_cause = ymd_tb_codes_pkg::CAUSE_SEQ_COMPL;
              end else if ({crc_hi, b} != crc_acc) begin
                res.kind = ymd_tb_codes_pkg::KIND_ERROR;
                res.error_cause = ymd_tb_codes_pkg::CAUSE_CRC;
              end else begin
                res.kind = ymd_tb_codes_pkg::KIND_GOOD;
                res.frame_length = frame_len[10:0];
              end
            end
          endcase
        end
      end
    endcase
    if (has_res) begin
      expected_results.push_back(res);
    end
  endtask

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch on result beat %0d: expected %0d, actual %0d",
                 $time, field, results_seen, want, got);
      end
    end
  endtask

  // compare one accepted result beat with the oldest prediction
  task automatic check_result();
    ymd_pkg::out_t want;
    results_seen++;
    if (out_mon.kind == ymd_tb_codes_pkg::KIND_GOOD) begin
      good_frames++;
    end
    if (out_mon.kind == ymd_tb_codes_pkg::KIND_ERROR) begin
      error_verdicts++;
    end
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: result beat %0d arrived with nothing expected: expected none, actual kind %0d",
                 $time, results_seen, out_mon.kind);
      end
    end else begin
      want = expected_results.pop_front();
      check_field("kind", want.kind, out_mon.kind);
      check_field("payload_byte", want.payload_byte, out_mon.payload_byte);
      check_field("payload_index", want.payload_index, out_mon.payload_index);
      check_field("seq_number", want.seq_number, out_mon.seq_number);
      check_field("frame_length", want.frame_length, out_mon.frame_length);
      check_field("error_cause", want.error_cause, out_mon.error_cause);
    end
  endtask

  // results are registered after their input beat is accepted, so check before predicting
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_phase = PH_IDLE;
      long_frame = 1'b0;
      payload_count = 0;
      crc_acc = '0;
      seq_byte = '0;
      seq_ok = 1'b0;
      crc_hi = '0;
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      if (in_mon.valid && in_mon.ready) begin
        deframe_step(in_mon.rx_byte, in_mon.timed_out);
      end
    end
    pending <= expected_results.size();
  end

endmodule

### tb/ymodem_packet_deframer_tb.sv
// ymodem_packet_deframer_tb: stimulus, output back-pressure and verdict for the YMODEM deframer.
// Depends on ymd_pkg, ymd_if, ymd_tb_codes_pkg, ymd_deframe_checker and the deframer RTL.
module ymodem_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHORT_LEN = 128;
  localparam int LONG_LEN = 1024;
  localparam int BEAT_TARGET = 700;
  localparam int DRAIN_CYCLES = 100;
  localparam int DRAIN_LIMIT = 5000;
  // worst case per beat is roughly the longest next_gap idle gap plus the longest ready_hold stall
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef enum int {FR_GOOD, FR_BAD_SEQ, FR_BAD_CRC, FR_BAD_BOTH, FR_CUT} frame_fault_e;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int          beats_sent = 0;
  int          short_frames = 0;
  int          long_frames = 0;
  int          gap_burst_left = 0;
  int          ready_run = 0;
  int          ready_hold = 0;
  logic [4:0]  faults_sent = '0;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          good_frames;
  int          error_verdicts;

  ymd_in_if  in_ch();
  ymd_out_if out_ch();

  ymodem_packet_deframer #(
    .SHORT_PAYLOAD(SHORT_LEN),
    .LONG_PAYLOAD (LONG_LEN)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  ymd_deframe_checker #(
    .SHORT_LEN(SHORT_LEN),
    .LONG_LEN (LONG_LEN)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .good_frames   (good_frames),
    .error_verdicts(error_verdicts)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles without finishing", cycle_count);
      $display("ymodem_packet_deframer regression: fail");
      $finish;
    end
  end

  // result back-pressure: ready stretches of random length, stalls mostly short
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (ready_run > 0) begin
      out_ch.ready <= 1'b1;
      ready_run = ready_run - 1;
    end else if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300) : $urandom_range(0, 12);
      case ($urandom_range(0, 19))
        0:       ready_hold = $urandom_range(20, 60);
        1, 2:    ready_hold = $urandom_range(4, 10);
        3:       ready_hold = 0;
        default: ready_hold = $urandom_range(1, 3);
      endcase
    end
  end

  // idle cycles before the next input beat; occasional bursts with none
  function automatic int next_gap();
    int r;
    if (gap_burst_left > 0) begin
      gap_burst_left--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r == 0) begin
      gap_burst_left = $urandom_range(40, 160);
      return 0;
    end
    if (r < 110) return 0;
    if (r < 170) return $urandom_range(1, 3);
    if (r < 194) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // drive one input beat and hold it until accepted
  task automatic put_beat(input logic [7:0] b, input logic tmo);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.rx_byte <= 8'($urandom_range(0, 255));
      in_ch.timed_out <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.timed_out <= tmo;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // payload content leans toward control codes and extremes
  function automatic logic [7:0] payload_value();
    case ($urandom_range(0, 24))
      0:       return ymd_tb_codes_pkg::CH_SOH;
      1:       return ymd_tb_codes_pkg::CH_STX;
      2:       return ymd_tb_codes_pkg::CH_EOT;
      3:       return ymd_tb_codes_pkg::CH_CAN;
      4:       return 8'h00;
      5:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // every kind of damage once early on, then at random
  function automatic frame_fault_e pick_fault();
    int r;
    for (int f = 0; f < 5; f++) begin
      if (!faults_sent[f]) return frame_fault_e'(f);
    end
    r = $urandom_range(0, 99);
    if (r < 45) return FR_GOOD;
    if (r < 60) return FR_BAD_SEQ;
    if (r < 75) return FR_BAD_CRC;
    if (r < 85) return FR_BAD_BOTH;
    return FR_CUT;
  endfunction

  // build one frame, optionally damaged or cut short by a timeout, and send it
  task automatic send_frame(input bit is_long, input frame_fault_e fault);
    logic [7:0]  frame_bytes[$];
    logic [7:0]  seq;
    logic [7:0]  pbyte;
    logic [7:0]  seq_flip;
    logic [15:0] crc;
    logic [15:0] crc_flip;
    int          len;
    int          cut;
    len = is_long ? LONG_LEN : SHORT_LEN;
    seq = 8'($urandom_range(0, 255));
    seq_flip = 8'($urandom_range(1, 255));
    crc_flip = 16'($urandom_range(1, 65535));
    crc = '0;
    frame_bytes.push_back(is_long ? ymd_tb_codes_pkg::CH_STX : ymd_tb_codes_pkg::CH_SOH);
    frame_bytes.push_back(seq);
    if (fault == FR_BAD_SEQ || fault == FR_BAD_BOTH) begin
      frame_bytes.push_back(~seq ^ seq_flip);
    end else begin
      frame_bytes.push_back(~seq);
    end
    repeat (len) begin
      pbyte = payload_value();
      crc = ymd_pkg::crc_byte(crc, pbyte);
      frame_bytes.push_back(pbyte);
    end
    if (fault == FR_BAD_CRC || fault == FR_BAD_BOTH) begin
      crc = crc ^ crc_flip;
    end
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    cut = frame_bytes.size();
    if (fault == FR_CUT) begin
      // long frames are only ever sent cut, to keep the run short
      if (is_long) begin
        cut = $urandom_range(1, 40);
      end else begin
        cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4)
                                          : $urandom_range(1, frame_bytes.size() - 1);
      end
    end
    for (int i = 0; i < cut; i++) begin
      put_beat(frame_bytes[i], 1'b0);
    end
    if (fault == FR_CUT) begin
      put_beat(8'($urandom_range(0, 255)), 1'b1);
    end
    faults_sent[fault] = 1'b1;
    if (is_long) begin
      long_frames++;
    end else begin
      short_frames++;
    end
  endtask

  initial begin
    int r;
    int waited;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    in_ch.timed_out <= 1'b0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle-state cases, cancel handling, timeouts at seq, complement and payload bytes
    put_beat(8'hA5, 1'b1);
    put_beat(8'h00, 1'b0);
    put_beat(8'hFF, 1'b0);
    put_beat(ymd_tb_codes_pkg::CH_EOT, 1'b0);
    put_beat(ymd_tb_codes_pkg::CH_CAN, 1'b0);
    put_beat(ymd_tb_codes_pkg::CH_CAN, 1'b0);
    put_beat(ymd_tb_codes_pkg::CH_CAN, 1'b0);
    put_beat(ymd_tb_codes_pkg::CH_SOH, 1'b0);
    // CAN value on a timeout beat must be ignored
    put_beat(ymd_tb_codes_pkg::CH_CAN, 1'b0);
    put_beat(ymd_tb_codes_pkg::CH_CAN, 1'b1);
    put_beat(ymd_tb_codes_pkg::CH_SOH, 1'b0);
    put_beat(8'h00, 1'b1);
    put_beat(ymd_tb_codes_pkg::CH_STX, 1'b0);
    put_beat(8'h5A, 1'b0);
    put_beat(8'h00, 1'b1);
    // start codes inside a frame are plain payload
    put_beat(ymd_tb_codes_pkg::CH_SOH, 1'b0);
    put_beat(8'hFF, 1'b0);
    put_beat(8'h00, 1'b0);
    put_beat(ymd_tb_codes_pkg::CH_SOH, 1'b0);
    put_beat(ymd_tb_codes_pkg::CH_CAN, 1'b0);
    put_beat(8'hFF, 1'b1);

    // random: mostly frames, with single codes, noise and junk mixed in
    while (beats_sent < BEAT_TARGET || faults_sent != '1) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_frame(1'b1, FR_CUT);
      end else if (r < 60) begin
        send_frame(1'b0, pick_fault());
      end else if (r < 68) begin
        put_beat(ymd_tb_codes_pkg::CH_EOT, 1'b0);
      end else if (r < 75) begin
        put_beat(ymd_tb_codes_pkg::CH_CAN, 1'b0);
        put_beat(ymd_tb_codes_pkg::CH_CAN, 1'b0);
      end else if (r < 80) begin
        put_beat(ymd_tb_codes_pkg::CH_CAN, 1'b0);
        put_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (r < 84) begin
        put_beat(8'($urandom_range(0, 255)), 1'b1);
      end else if (r < 94) begin
        // a byte that cannot open anything
        do r = $urandom_range(0, 255);
        while (r == ymd_tb_codes_pkg::CH_SOH || r == ymd_tb_codes_pkg::CH_STX ||
               r == ymd_tb_codes_pkg::CH_CAN);
        put_beat(8'(r), 1'b0);
      end else begin
        // junk burst, then a timeout to get back to idle from anywhere
        repeat ($urandom_range(1, 6)) begin
          put_beat(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
        put_beat(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    if (long_frames == 0) begin
      send_frame(1'b1, FR_CUT);
    end

    // drain
    in_ch.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending != 0) begin
      $display("%0d expected result beats never arrived", pending);
    end

    $display("sent %0d input beats: %0d short and %0d long frames, damaged and cut ones included",
             beats_sent, short_frames, long_frames);
    $display("checked %0d result beats: %0d good frames, %0d error verdicts",
             results_seen, good_frames, error_verdicts);
    if (fail_count == 0 && pending == 0) begin
      $display("ymodem_packet_deframer regression: pass");
    end else begin
      $display("ymodem_packet_deframer regression: fail");
    end
    $finish;
  end

endmodule
